// ----- rtl/link_slot_finder_top_macros.svh -----
// Assertion macros shared by the slot finder checker.
// Depends on nothing; included by the checker file.
`ifndef LINK_SLOT_FINDER_TOP_MACROS_SVH
`define LINK_SLOT_FINDER_TOP_MACROS_SVH
// implication check, reset disables
`define LSF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lsf check failed");
// next-cycle implication check
`define LSF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lsf check failed");
`endif

// ----- rtl/lsf_pkg.sv -----
// Package for the link slot finder: actions, widths, status codes.
// Depends on nothing.
package lsf_pkg;
	localparam int TICK_W = 32;
	localparam int POS_W  = 6;
	typedef enum logic [1:0] {
		ACT_QUERY  = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;
	localparam logic CFG_BANDWIDTH = 1'b0;
	localparam logic CFG_LATENCY   = 1'b1;
	typedef struct packed {
		logic [1:0]        action;
		logic [TICK_W-1:0] ready_time;
		logic [TICK_W-1:0] data_amount;
		logic [TICK_W-1:0] busy_start;
		logic [TICK_W-1:0] busy_end;
	} req_t;
	typedef struct packed {
		logic [TICK_W-1:0] slot_start;
		logic [TICK_W-1:0] slot_end;
		logic [POS_W-1:0]  position;
		logic              status;
	} rsp_t;
	typedef struct packed {
		logic       index;
		logic [15:0] data;
	} cfg_t;
endpackage

// ----- rtl/lsf_if.sv -----
// Valid/ready channel interfaces for request, response and configuration words.
// Depends on lsf_pkg.
interface lsf_req_if import lsf_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lsf_rsp_if import lsf_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lsf_cfg_if import lsf_pkg::*; ();
	logic valid;
	logic ready;
	cfg_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/link_slot_finder_top.sv -----
// Link slot finder: busy interval table in two synchronous memories; needs lsf_pkg, lsf_if.
// Throughput: one word at a time. The 32-step restoring divider and the single
// memory read port walking table entries set the cycle count. Reset clears entry
// count, registers (bw_q to 1, lat_q to 0) and control; table memories are not
// cleared.
module link_slot_finder_top
	import lsf_pkg::*;
#(
	parameter int MAX_INTERVALS = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	lsf_req_if.sink  req,
	lsf_rsp_if.source rsp,
	lsf_cfg_if.sink  cfg
);
	localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
	localparam int CW = $clog2(MAX_INTERVALS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_INTERVALS);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_DIV   = 9'b000000010,
		ST_QRD0  = 9'b000000100,
		ST_QCHK  = 9'b000001000,
		ST_QWALK = 9'b000010000,
		ST_ISRCH = 9'b000100000,
		ST_ICHK  = 9'b001000000,
		ST_ISHFT = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;

	state_t state_q;
	req_t req_q;
	logic [15:0] bw_q, lat_q;
	logic [CW-1:0] cnt_q;
	// table memories
	logic [TICK_W-1:0] mem_s [MAX_INTERVALS];
	logic [TICK_W-1:0] mem_e [MAX_INTERVALS];
	logic [AW-1:0] rd_addr, wr_addr;
	logic wr_en;
	logic [TICK_W-1:0] wr_s, wr_e, rd_s_q, rd_e_q;
	// divider
	logic [TICK_W-1:0] quo_q, rem_q;
	logic [5:0] dstep_q;
	logic [TICK_W:0] dur_q;
	// walk
	logic [CW-1:0] idx_q;
	logic [TICK_W-1:0] floor_q, start_q;
	logic [CW-1:0] pos_q;
	logic phase_q;
	rsp_t rsp_q;
	logic rsp_valid_q;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE) && !rsp_valid_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_s[wr_addr] <= wr_s;
			mem_e[wr_addr] <= wr_e;
		end
		rd_s_q <= mem_s[rd_addr];
		rd_e_q <= mem_e[rd_addr];
	end

	// divider step and helpers
	logic [TICK_W:0] rem_sh;
	logic [15:0] bw_eff;
	logic [TICK_W+1:0] ready_plus;
	logic [TICK_W-1:0] e_max;
	logic [TICK_W:0] gap;
	logic [TICK_W+1:0] end_sum;
	always_comb begin
		bw_eff = (bw_q == 16'd0) ? 16'd1 : bw_q;
		rem_sh = {rem_q, quo_q[TICK_W-1]};
		ready_plus = {2'b0, req_q.ready_time} + {1'b0, dur_q};
		e_max = (rd_e_q > req_q.ready_time) ? rd_e_q : req_q.ready_time;
		gap = {1'b0, rd_s_q} - {1'b0, floor_q};
		end_sum = {2'b0, start_q} + {1'b0, dur_q};
	end

	// read address and write control
	always_comb begin
		rd_addr = idx_q[AW-1:0];
		wr_en = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_s = rd_s_q;
		wr_e = rd_e_q;
		if (state_q == ST_ISHFT && phase_q) begin
			wr_en = 1'b1;
			if (idx_q == pos_q) begin
				wr_s = req_q.busy_start;
				wr_e = req_q.busy_end;
			end
		end
		if (state_q == ST_ISHFT)
			rd_addr = AW'(idx_q - CW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bw_q <= 16'd1;
			lat_q <= 16'd0;
			cnt_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				if (cfg.data.index == CFG_BANDWIDTH) bw_q <= cfg.data.data;
				else lat_q <= cfg.data.data;
			end
			if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
			case (state_q)
			ST_IDLE: begin
				if (req.valid && !rsp_valid_q) begin
					req_q <= req.data;
					idx_q <= '0;
					phase_q <= 1'b0;
					quo_q <= req.data.data_amount;
					rem_q <= '0;
					dstep_q <= '0;
					case (action_t'(req.data.action))
					ACT_QUERY: state_q <= ST_DIV;
					ACT_INSERT: begin
						if (cnt_q >= MAX_CNT) begin
							rsp_q <= '{slot_start: '0, slot_end: '0,
								position: POS_W'(cnt_q), status: STATUS_FULL};
							rsp_valid_q <= 1'b1;
						end else
							state_q <= ST_ISRCH;
					end
					ACT_CLEAR: begin
						cnt_q <= '0;
						rsp_q <= '0;
						rsp_valid_q <= 1'b1;
					end
					default: begin
						rsp_q <= '0;
						rsp_valid_q <= 1'b1;
					end
					endcase
				end
			end
			ST_DIV: begin
				if (rem_sh >= {17'b0, bw_eff}) begin
					rem_q <= TICK_W'(rem_sh - {17'b0, bw_eff});
					quo_q <= {quo_q[TICK_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[TICK_W-1:0];
					quo_q <= {quo_q[TICK_W-2:0], 1'b0};
				end
				dstep_q <= dstep_q + 6'd1;
				if (dstep_q == 6'd31) state_q <= ST_QRD0;
			end
			ST_QRD0: begin
				// quotient is zero when amount is zero, so no special case
				dur_q <= {1'b0, quo_q} + {17'b0, lat_q};
				idx_q <= '0;
				if (cnt_q == '0) begin
					start_q <= req_q.ready_time;
					pos_q <= '0;
					state_q <= ST_OUT;
				end else
					state_q <= ST_QCHK;
			end
			ST_QCHK: begin
				// rd data is entry 0
				if ({2'b0, rd_s_q} > ready_plus) begin
					start_q <= req_q.ready_time;
					pos_q <= '0;
					state_q <= ST_OUT;
				end else begin
					floor_q <= e_max;
					if (cnt_q == CW'(1)) begin
						start_q <= e_max;
						pos_q <= cnt_q;
						state_q <= ST_OUT;
					end else begin
						idx_q <= CW'(1);
						phase_q <= 1'b0;
						state_q <= ST_QWALK;
					end
				end
			end
			ST_QWALK: begin
				// phase 0 waits for read of entry idx
				phase_q <= ~phase_q;
				if (phase_q) begin
					if (!gap[TICK_W] && gap >= dur_q) begin
						start_q <= floor_q;
						pos_q <= idx_q;
						state_q <= ST_OUT;
					end else if (idx_q == cnt_q - CW'(1)) begin
						start_q <= e_max;
						pos_q <= cnt_q;
						state_q <= ST_OUT;
					end else begin
						floor_q <= e_max;
						idx_q <= idx_q + CW'(1);
					end
				end
			end
			ST_ISRCH: begin
				if (idx_q == cnt_q) begin
					pos_q <= idx_q;
					idx_q <= cnt_q;
					phase_q <= 1'b0;
					state_q <= ST_ISHFT;
				end else state_q <= ST_ICHK;
			end
			ST_ICHK: begin
				if (rd_s_q <= req_q.busy_start) begin
					idx_q <= idx_q + CW'(1);
					state_q <= ST_ISRCH;
				end else begin
					pos_q <= idx_q;
					idx_q <= cnt_q;
					phase_q <= 1'b0;
					state_q <= ST_ISHFT;
				end
			end
			ST_ISHFT: begin
				// phase 0 reads entry idx-1, phase 1 writes entry idx
				phase_q <= ~phase_q;
				if (phase_q) begin
					if (idx_q == pos_q) begin
						cnt_q <= cnt_q + CW'(1);
						rsp_q <= '{slot_start: '0, slot_end: '0,
							position: POS_W'(pos_q), status: STATUS_OK};
						rsp_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end else idx_q <= idx_q - CW'(1);
				end
			end
			ST_OUT: begin
				rsp_q <= '{slot_start: start_q,
					slot_end: end_sum[TICK_W+1:TICK_W] != 2'b0 ? '1 : end_sum[TICK_W-1:0],
					position: POS_W'(pos_q), status: STATUS_OK};
				rsp_valid_q <= 1'b1;
				state_q <= ST_IDLE;
			end
			default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/lsf_checker.sv -----
// Port-level checker for the link slot finder, bound to the top level.
// Depends on lsf_pkg and the macro header.
`include "link_slot_finder_top_macros.svh"
module lsf_checker
	import lsf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data
);
	// no new word taken while a result waits
	`LSF_ASSERT_IMP(a_no_take_pending, clk, arst_n, rsp_valid, !req_ready)
	// a taken word leaves the block busy next cycle
	`LSF_ASSERT_NXT(a_busy_after, clk, arst_n, req_valid && req_ready, !req_ready)
	// a full result (refused insert) carries zero times, no window
	`LSF_ASSERT_IMP(a_full_zero, clk, arst_n, rsp_valid && rsp_data.status,
		rsp_data.slot_start == '0 && rsp_data.slot_end == '0)
	// a window never ends before it starts
	`LSF_ASSERT_IMP(a_order, clk, arst_n, rsp_valid,
		rsp_data.slot_end >= rsp_data.slot_start)
	// a result not taken stays put
	`LSF_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready,
		rsp_valid && $stable(rsp_data))
endmodule

bind link_slot_finder_top lsf_checker u_lsf_checker (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
